[sv/kped_pkg.sv]
// Shared types, codes and constants of the key press event detector.
package kped_pkg;

  localparam int KEY_COUNT_DEF = 5;
  localparam int LEVEL_W       = 5;
  localparam int TIME_W        = 32;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CNT_W         = 8;
  localparam int KIDX_W        = 3;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd20;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [CFG_W-1:0] REPEAT_RST     = 16'd200;
  localparam logic [CFG_W-1:0] CLICK_GAP_RST  = 16'd300;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_LONG_PRESS = 2'd1,
    CFG_REPEAT     = 2'd2,
    CFG_CLICK_GAP  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HELD = 2'd1,
    PH_QUAL = 2'd2,
    PH_LONG = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic update;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } status_t;

endpackage

[sv/kped_ctrl.sv]
// Scan sequencer: accepts a request and walks the keys through the datapath.
module kped_ctrl import kped_pkg::*; #(
  parameter int KEY_COUNT = KEY_COUNT_DEF,
  localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  status_t       status,
  output cmd_t          cmd,
  output logic [KW-1:0] key_idx
);

  localparam logic [KW-1:0] KEY_LAST = KW'(KEY_COUNT - 1);

  state_t        state_r, state_nxt;
  logic [KW-1:0] key_r, key_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      key_r   <= '0;
    end else begin
      state_r <= state_nxt;
      key_r   <= key_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    key_nxt   = key_r;
    cmd       = '0;
    cmd.last  = (key_r == KEY_LAST);
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          key_nxt   = '0;
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (!status.out_full) begin
          cmd.update = 1'b1;
          if (key_r == KEY_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            key_nxt   = key_r + 1'b1;
            state_nxt = ST_CALC;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign key_idx = key_r;

endmodule

[sv/kped_dp.sv]
// Per-key state, configuration registers, event logic and result register.
module kped_dp import kped_pkg::*; #(
  parameter int KEY_COUNT = KEY_COUNT_DEF,
  localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  input  logic [KW-1:0]        key_idx,
  output status_t              status,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [LEVEL_W-1:0]   in_key_levels,
  input  logic [TIME_W-1:0]    in_now_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KIDX_W-1:0]    out_key_index,
  output logic                 out_press_event,
  output logic                 out_release_event,
  output logic                 out_long_press_event,
  output logic                 out_repeat_event,
  output logic                 out_click_report,
  output logic [CNT_W-1:0]     out_click_count,
  output logic [TIME_W-1:0]    out_press_duration_ms,
  output logic                 out_last_key
);

  logic [CFG_W-1:0] debounce_r, long_press_r, repeat_r, click_gap_r;

  logic [LEVEL_W-1:0]   levels_r;
  logic [TIME_W-1:0]    now_r;
  logic [KEY_COUNT-1:0] levels_ext;

  phase_t            phase_r [KEY_COUNT];
  logic [TIME_W-1:0] start_r [KEY_COUNT];
  logic [TIME_W-1:0] held_r  [KEY_COUNT];
  logic [CNT_W-1:0]  cnt_r   [KEY_COUNT];
  logic [TIME_W-1:0] click_r [KEY_COUNT];
  logic [TIME_W-1:0] due_r   [KEY_COUNT];

  logic [TIME_W-1:0] held_calc_r, gap_diff_r, rep_diff_r;

  phase_t            phase_nxt;
  logic [TIME_W-1:0] start_nxt, held_nxt, click_nxt, due_nxt;
  logic [CNT_W-1:0]  cnt_nxt;
  logic ev_press, ev_rel, ev_long, ev_rep, ev_click;
  logic [CNT_W-1:0]  rep_cnt;
  logic [TIME_W-1:0] dur;
  logic              down, reached;

  logic                 out_valid_r;
  logic [KIDX_W-1:0]    key_index_r;
  logic                 press_r, release_r, long_r, repeat_ev_r, click_rep_r, last_r;
  logic [CNT_W-1:0]     click_cnt_r;
  logic [TIME_W-1:0]    dur_r;
  logic [TIME_W-1:0]    key_wide;

  generate
    if (KEY_COUNT <= LEVEL_W) begin : g_lv_narrow
      assign levels_ext = levels_r[KEY_COUNT-1:0];
    end else begin : g_lv_wide
      assign levels_ext = {{(KEY_COUNT - LEVEL_W){1'b0}}, levels_r};
    end
  endgenerate

  assign key_wide = TIME_W'(key_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_press_r <= LONG_PRESS_RST;
      repeat_r     <= REPEAT_RST;
      click_gap_r  <= CLICK_GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE:   debounce_r   <= cfg_wdata;
        CFG_LONG_PRESS: long_press_r <= cfg_wdata;
        CFG_REPEAT:     repeat_r     <= cfg_wdata;
        CFG_CLICK_GAP:  click_gap_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      levels_r <= in_key_levels;
      now_r    <= in_now_ms;
    end
  end

  // differences against the stored times of the current key
  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      held_calc_r <= (phase_r[key_idx] == PH_IDLE) ? '0 : now_r - start_r[key_idx];
      gap_diff_r  <= now_r - click_r[key_idx];
      rep_diff_r  <= now_r - due_r[key_idx];
    end
  end

  always_comb begin
    down      = levels_ext[key_idx];
    phase_nxt = phase_r[key_idx];
    start_nxt = start_r[key_idx];
    held_nxt  = held_r[key_idx];
    cnt_nxt   = cnt_r[key_idx];
    click_nxt = click_r[key_idx];
    due_nxt   = due_r[key_idx];
    ev_press  = 1'b0;
    ev_rel    = 1'b0;
    ev_long   = 1'b0;
    ev_rep    = 1'b0;
    ev_click  = 1'b0;
    rep_cnt   = '0;
    dur       = '0;
    reached   = 1'b0;
    if (down) begin
      if (phase_nxt == PH_IDLE) begin
        phase_nxt = PH_HELD;
        start_nxt = now_r;
      end
      held_nxt = held_calc_r;
      if (phase_nxt == PH_HELD && held_calc_r >= TIME_W'(debounce_r)) begin
        phase_nxt = PH_QUAL;
        ev_press  = 1'b1;
        if (cnt_nxt == '0) begin
          cnt_nxt = CNT_W'(1);
        end else if (gap_diff_r <= TIME_W'(click_gap_r) && cnt_nxt != CNT_MAX) begin
          cnt_nxt = cnt_nxt + 1'b1;
        end
        click_nxt = now_r;
      end
      if (phase_nxt == PH_QUAL && held_calc_r >= TIME_W'(long_press_r)) begin
        phase_nxt = PH_LONG;
        ev_long   = 1'b1;
        due_nxt   = now_r + TIME_W'(repeat_r);
      end
      reached = ev_long ? (repeat_r == '0) : !rep_diff_r[TIME_W-1];
      if (phase_nxt == PH_LONG && held_calc_r >= TIME_W'(long_press_r) && reached) begin
        due_nxt = now_r + TIME_W'(repeat_r);
        ev_rep  = 1'b1;
      end
    end else begin
      if (gap_diff_r > TIME_W'(click_gap_r) && cnt_nxt != '0) begin
        ev_click = 1'b1;
        rep_cnt  = cnt_nxt;
        cnt_nxt  = '0;
      end
      if (phase_nxt != PH_IDLE) begin
        phase_nxt = PH_IDLE;
        ev_rel    = 1'b1;
        dur       = held_r[key_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_COUNT; i++) begin
        phase_r[i] <= PH_IDLE;
        start_r[i] <= '0;
        held_r[i]  <= '0;
        cnt_r[i]   <= '0;
        click_r[i] <= '0;
        due_r[i]   <= '0;
      end
    end else if (cmd.update) begin
      phase_r[key_idx] <= phase_nxt;
      start_r[key_idx] <= start_nxt;
      held_r[key_idx]  <= held_nxt;
      cnt_r[key_idx]   <= cnt_nxt;
      click_r[key_idx] <= click_nxt;
      due_r[key_idx]   <= due_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.update) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      key_index_r <= key_wide[KIDX_W-1:0];
      press_r     <= ev_press;
      release_r   <= ev_rel;
      long_r      <= ev_long;
      repeat_ev_r <= ev_rep;
      click_rep_r <= ev_click;
      click_cnt_r <= rep_cnt;
      dur_r       <= dur;
      last_r      <= cmd.last;
    end
  end

  assign status.out_full       = out_valid_r && !out_ready;
  assign out_valid             = out_valid_r;
  assign out_key_index         = key_index_r;
  assign out_press_event       = press_r;
  assign out_release_event     = release_r;
  assign out_long_press_event  = long_r;
  assign out_repeat_event      = repeat_ev_r;
  assign out_click_report      = click_rep_r;
  assign out_click_count       = click_cnt_r;
  assign out_press_duration_ms = dur_r;
  assign out_last_key          = last_r;

endmodule

[sv/key_press_event_detector_top.sv]
// Top level of the key press event detector: sequencer plus datapath.
// One scan request carries the key levels and the millisecond time and yields one
// result per key, in key order, with the final one marked by out_last_key. A scan
// accepts the request in the idle state, then passes each key through a difference
// stage and an update stage of the single shared event unit. A stalled result
// holds the update of the following key. A new request is taken once the last key
// of the scan has been updated, while its result may still wait at the output.
module key_press_event_detector_top import kped_pkg::*; #(
  parameter int KEY_COUNT = KEY_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [LEVEL_W-1:0]   in_key_levels,
  input  logic [TIME_W-1:0]    in_now_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KIDX_W-1:0]    out_key_index,
  output logic                 out_press_event,
  output logic                 out_release_event,
  output logic                 out_long_press_event,
  output logic                 out_repeat_event,
  output logic                 out_click_report,
  output logic [CNT_W-1:0]     out_click_count,
  output logic [TIME_W-1:0]    out_press_duration_ms,
  output logic                 out_last_key
);

  localparam int KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  cmd_t          cmd;
  status_t       status;
  logic [KW-1:0] key_idx;

  kped_ctrl #(.KEY_COUNT(KEY_COUNT)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd),
    .key_idx  (key_idx)
  );

  kped_dp #(.KEY_COUNT(KEY_COUNT)) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .key_idx               (key_idx),
    .status                (status),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_key_levels         (in_key_levels),
    .in_now_ms             (in_now_ms),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_key_index         (out_key_index),
    .out_press_event       (out_press_event),
    .out_release_event     (out_release_event),
    .out_long_press_event  (out_long_press_event),
    .out_repeat_event      (out_repeat_event),
    .out_click_report      (out_click_report),
    .out_click_count       (out_click_count),
    .out_press_duration_ms (out_press_duration_ms),
    .out_last_key          (out_last_key)
  );

  a_one_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while a scan is in progress");

  a_mid_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_key |-> !in_ready)
    else $error("sequencer idle before the last key of the scan");

  a_press_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_press_event |-> !out_release_event)
    else $error("press and release reported together");

  a_count_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_click_report |-> out_click_count == '0)
    else $error("click count without a click report");

endmodule

[tb/tb.sv]
// Testbench for the key press event detector: directed and random scans checked per key.
`timescale 1ns / 100ps

module tb import kped_pkg::*;;

  localparam int KEYS        = KEY_COUNT_DEF;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [KIDX_W-1:0] key_index;
    logic              press_ev;
    logic              release_ev;
    logic              long_ev;
    logic              repeat_ev;
    logic              click_ev;
    logic [CNT_W-1:0]  click_count;
    logic [TIME_W-1:0] duration;
    logic              last_key;
  } key_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  cfg_idx_t             cfg_index = CFG_DEBOUNCE;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [LEVEL_W-1:0]   in_key_levels = '0;
  logic [TIME_W-1:0]    in_now_ms = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [KIDX_W-1:0]    out_key_index;
  logic                 out_press_event;
  logic                 out_release_event;
  logic                 out_long_press_event;
  logic                 out_repeat_event;
  logic                 out_click_report;
  logic [CNT_W-1:0]     out_click_count;
  logic [TIME_W-1:0]    out_press_duration_ms;
  logic                 out_last_key;

  // expected per-key events and detector state mirror
  key_result_t      expected_events[$];
  logic [CFG_W-1:0] debounce_ms, long_press_ms, repeat_ms, click_gap_ms;
  phase_t           phase_mirror [KEYS];
  logic [TIME_W-1:0] press_start [KEYS];
  logic [TIME_W-1:0] held_ms [KEYS];
  logic [CNT_W-1:0]  click_run [KEYS];
  logic [TIME_W-1:0] last_click [KEYS];
  logic [TIME_W-1:0] next_repeat [KEYS];

  int mismatches = 0;
  int quiet_cycles = 0;
  int sink_stall = 0;
  bit no_idle = 1'b0;

  key_press_event_detector_top i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_key_levels        (in_key_levels),
    .in_now_ms            (in_now_ms),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_key_index        (out_key_index),
    .out_press_event      (out_press_event),
    .out_release_event    (out_release_event),
    .out_long_press_event (out_long_press_event),
    .out_repeat_event     (out_repeat_event),
    .out_click_report     (out_click_report),
    .out_click_count      (out_click_count),
    .out_press_duration_ms(out_press_duration_ms),
    .out_last_key         (out_last_key)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(1, 3);
    if (r < 9) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_detector();
    debounce_ms   = DEBOUNCE_RST;
    long_press_ms = LONG_PRESS_RST;
    repeat_ms     = REPEAT_RST;
    click_gap_ms  = CLICK_GAP_RST;
    for (int k = 0; k < KEYS; k++) begin
      phase_mirror[k] = PH_IDLE;
      press_start[k]  = '0;
      held_ms[k]      = '0;
      click_run[k]    = '0;
      last_click[k]   = '0;
      next_repeat[k]  = '0;
    end
  endfunction

  function automatic void predict_key_events(logic [LEVEL_W-1:0] levels,
                                             logic [TIME_W-1:0] now);
    key_result_t       r;
    logic [TIME_W-1:0] since;
    for (int k = 0; k < KEYS; k++) begin
      r = '0;
      r.key_index = k[KIDX_W-1:0];
      r.last_key  = (k == KEYS - 1);
      if (levels[k]) begin
        if (phase_mirror[k] == PH_IDLE) begin
          phase_mirror[k] = PH_HELD;
          press_start[k]  = now;
        end
        held_ms[k] = now - press_start[k];
        if (phase_mirror[k] == PH_HELD && held_ms[k] >= debounce_ms) begin
          phase_mirror[k] = PH_QUAL;
          r.press_ev      = 1'b1;
          since = now - last_click[k];
          if (click_run[k] == '0)
            click_run[k] = CNT_W'(1);
          else if (since <= click_gap_ms && click_run[k] != CNT_MAX)
            click_run[k] = click_run[k] + 1'b1;
          last_click[k] = now;
        end
        if (phase_mirror[k] == PH_QUAL && held_ms[k] >= long_press_ms) begin
          phase_mirror[k] = PH_LONG;
          r.long_ev       = 1'b1;
          next_repeat[k]  = now + repeat_ms;
        end
        since = now - next_repeat[k];
        if (phase_mirror[k] == PH_LONG && held_ms[k] >= long_press_ms
            && !since[TIME_W-1]) begin
          next_repeat[k] = now + repeat_ms;
          r.repeat_ev    = 1'b1;
        end
      end else begin
        since = now - last_click[k];
        if (since > click_gap_ms && click_run[k] != '0) begin
          r.click_ev    = 1'b1;
          r.click_count = click_run[k];
          click_run[k]  = '0;
        end
        if (phase_mirror[k] != PH_IDLE) begin
          phase_mirror[k] = PH_IDLE;
          r.release_ev    = 1'b1;
          r.duration      = held_ms[k];
        end
      end
      expected_events.push_back(r);
    end
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // check each accepted result against the oldest expectation
  always @(posedge clk) begin
    key_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual key %0d", $time, out_key_index);
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        compare_field("key_index", want.key_index, out_key_index);
        compare_field("press_event", want.press_ev, out_press_event);
        compare_field("release_event", want.release_ev, out_release_event);
        compare_field("long_press_event", want.long_ev, out_long_press_event);
        compare_field("repeat_event", want.repeat_ev, out_repeat_event);
        compare_field("click_report", want.click_ev, out_click_report);
        compare_field("click_count", want.click_count, out_click_count);
        compare_field("press_duration_ms", want.duration, out_press_duration_ms);
        compare_field("last_key", want.last_key, out_last_key);
      end
    end
  end

  always @(posedge clk) begin
    if (sink_stall > 0)
      sink_stall--;
    else if (!no_idle && $urandom_range(0, 3) == 0)
      sink_stall = idle_len();
    out_ready <= (sink_stall == 0);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_scan(input logic [LEVEL_W-1:0] levels, input logic [TIME_W-1:0] now);
    int gap;
    in_valid      <= 1'b1;
    in_key_levels <= levels;
    in_now_ms     <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_key_events(levels, now);
    gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_results_done();
    while (expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_DEBOUNCE:   debounce_ms   = value;
      CFG_LONG_PRESS: long_press_ms = value;
      CFG_REPEAT:     repeat_ms     = value;
      CFG_CLICK_GAP:  click_gap_ms  = value;
      default: ;
    endcase
  endtask

  task automatic set_timing(input logic [CFG_W-1:0] debounce, input logic [CFG_W-1:0] hold,
                            input logic [CFG_W-1:0] rpt, input logic [CFG_W-1:0] gap);
    in_valid <= 1'b0;
    wait_results_done();
    write_reg(CFG_DEBOUNCE, debounce);
    write_reg(CFG_LONG_PRESS, hold);
    write_reg(CFG_REPEAT, rpt);
    write_reg(CFG_CLICK_GAP, gap);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_timing();
    logic [TIME_W-1:0] t0;
    t0 = 32'h0000_1000;
    send_scan(5'b10001, t0);
    send_scan(5'b10001, t0 + 19);
    send_scan(5'b10001, t0 + 20);
    send_scan(5'b10001, t0 + 1000);
    send_scan(5'b10001, t0 + 1199);
    send_scan(5'b10001, t0 + 1200);
    send_scan(5'b00000, t0 + 1250);
    send_scan(5'b00000, t0 + 1600);
  endtask

  task automatic test_click_gap();
    logic [TIME_W-1:0] t0;
    set_timing(16'd10, 16'd1000, 16'd200, 16'd100);
    t0 = 32'h0002_0000;
    send_scan(5'b00110, t0);
    send_scan(5'b00110, t0 + 10);
    send_scan(5'b00000, t0 + 20);
    send_scan(5'b00110, t0 + 200);
    send_scan(5'b00110, t0 + 215);
    send_scan(5'b00000, t0 + 220);
    send_scan(5'b00000, t0 + 400);
  endtask

  task automatic test_extremes();
    logic [TIME_W-1:0] t0;
    set_timing(16'd0, 16'd0, 16'd0, 16'd0);
    t0 = 32'h00A0_0000;
    send_scan(5'b11111, t0);
    send_scan(5'b11111, t0);
    send_scan(5'b00000, t0);
    send_scan(5'b00000, t0 + 1);
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    t0 = 32'h0100_0000;
    send_scan(5'b10101, t0);
    send_scan(5'b10101, t0 + 65535);
    send_scan(5'b10101, t0 + 131070);
    send_scan(5'b01010, t0 + 131070);
    send_scan(5'b00000, t0 + 196606);
  endtask

  task automatic test_time_wrap();
    logic [TIME_W-1:0] t0;
    set_timing(DEBOUNCE_RST, LONG_PRESS_RST, REPEAT_RST, CLICK_GAP_RST);
    t0 = 32'hFFFF_FF80;
    send_scan(5'b11111, t0);
    send_scan(5'b11111, t0 + 20);
    send_scan(5'b11111, t0 + 1000);
    send_scan(5'b11111, t0 + 1200);
    send_scan(5'b00000, t0 + 1300);
    send_scan(5'b00000, t0 + 1700);
  endtask

  function automatic logic [CFG_W-1:0] pick_edge_value(int unsigned small_max);
    case ($urandom_range(0, 2))
      0: return '0;
      1: return '1;
      default: return CFG_W'($urandom_range(0, small_max));
    endcase
  endfunction

  task automatic run_random_phase(input int unsigned scale, input int count);
    logic [TIME_W-1:0]  t_ms;
    logic [LEVEL_W-1:0] levels;
    logic [31:0]        flip;
    int                 r;
    t_ms   = $urandom;
    levels = '0;
    for (int i = 0; i < count; i++) begin
      flip   = $urandom & $urandom;
      levels = levels ^ flip[LEVEL_W-1:0];
      if ($urandom_range(0, 15) == 0) levels = LEVEL_W'($urandom);
      r = $urandom_range(0, 99);
      if (r < 65)
        t_ms = t_ms + $urandom_range(0, scale);
      else if (r < 97)
        t_ms = t_ms + $urandom_range(scale, 4 * scale);
      else
        t_ms = $urandom;
      send_scan(levels, t_ms);
    end
  endtask

  task automatic test_random_traffic();
    set_timing(CFG_W'($urandom_range(0, 20)), CFG_W'($urandom_range(0, 150)),
               CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(0, 80)));
    run_random_phase(30, 70);
    no_idle = 1'b1;
    set_timing(CFG_W'($urandom_range(0, 20)), CFG_W'($urandom_range(0, 150)),
               CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(0, 80)));
    run_random_phase(30, 70);
    no_idle = 1'b0;
    set_timing(CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)),
               CFG_W'($urandom_range(0, 65535)), CFG_W'($urandom_range(0, 65535)));
    run_random_phase(20000, 70);
    set_timing(pick_edge_value(30), pick_edge_value(300), pick_edge_value(50),
               pick_edge_value(100));
    run_random_phase(1000, 70);
  endtask

  initial begin
    clear_detector();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_timing();
    test_click_gap();
    test_extremes();
    test_time_wrap();
    test_random_traffic();
    in_valid <= 1'b0;
    wait_results_done();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
